>>> rtl/skf_pkg.sv
// Shared types, constants, saturating helpers and the microcode table
// for the scalar Kalman filter. No dependencies.
package skf_pkg;

  localparam int DW    = 32;          // data word, signed fixed point
  localparam int FB    = 16;          // fraction bits
  localparam int UW    = DW - 1;      // width of the non-negative values
  localparam int MAG_W = DW + FB;     // magnitude before saturation
  localparam int PC_W  = 5;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = DW'(1) << FB;
  localparam logic [MAG_W-1:0] POS_LIM  = (MAG_W'(1) << (DW - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] NEG_LIM  = MAG_W'(1) << (DW - 1);

  // configuration register indexes
  localparam logic [2:0] REG_F        = 3'd0;
  localparam logic [2:0] REG_Q        = 3'd1;
  localparam logic [2:0] REG_H        = 3'd2;
  localparam logic [2:0] REG_R        = 3'd3;
  localparam logic [2:0] REG_INIT_EST = 3'd4;
  localparam logic [2:0] REG_INIT_COV = 3'd5;

  typedef enum logic [2:0] {
    OP_IDLE, OP_NOP, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_ONE, SRC_F, SRC_H, SRC_Q, SRC_R, SRC_Z, SRC_X, SRC_P,
    SRC_X0, SRC_P0, SRC_T, SRC_DEN, SRC_K, SRC_ACC
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_X, DST_P, DST_X0, DST_P0, DST_T, DST_DEN, DST_K, DST_ACC
  } dst_t;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_ALWAYS, JMP_DEN_LE0
  } jmp_t;

  typedef struct packed {
    op_t             op;
    src_t            a;
    src_t            b;
    dst_t            dst;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic mul_done;
    logic div_done;
    logic den_le0;
  } stat_t;

  function automatic ucw_t uw(op_t op, src_t a, src_t b, dst_t dst, jmp_t jmp,
                              logic [PC_W-1:0] target);
    ucw_t w;
    w.op = op; w.a = a; w.b = b; w.dst = dst; w.jmp = jmp; w.target = target;
    return w;
  endfunction

  // Program: predict, gain, correct, emit.
  function automatic ucw_t ucode(logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:    w = uw(OP_IDLE, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_NONE, 5'd0);
      5'd1:    w = uw(OP_MUL, SRC_F, SRC_F, DST_ACC, JMP_NONE, 5'd0);
      5'd2:    w = uw(OP_MUL, SRC_F, SRC_X, DST_X0, JMP_NONE, 5'd0);
      5'd3:    w = uw(OP_MUL, SRC_ACC, SRC_P, DST_ACC, JMP_NONE, 5'd0);
      5'd4:    w = uw(OP_ADD, SRC_ACC, SRC_Q, DST_P0, JMP_NONE, 5'd0);
      5'd5:    w = uw(OP_MUL, SRC_H, SRC_P0, DST_T, JMP_NONE, 5'd0);
      5'd6:    w = uw(OP_MUL, SRC_T, SRC_H, DST_ACC, JMP_NONE, 5'd0);
      5'd7:    w = uw(OP_ADD, SRC_ACC, SRC_R, DST_DEN, JMP_NONE, 5'd0);
      5'd8:    w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_DEN_LE0, 5'd10);
      5'd9:    w = uw(OP_DIV, SRC_T, SRC_DEN, DST_K, JMP_ALWAYS, 5'd11);
      5'd10:   w = uw(OP_ADD, SRC_ZERO, SRC_ZERO, DST_K, JMP_NONE, 5'd0);
      5'd11:   w = uw(OP_MUL, SRC_H, SRC_X0, DST_ACC, JMP_NONE, 5'd0);
      5'd12:   w = uw(OP_SUB, SRC_Z, SRC_ACC, DST_ACC, JMP_NONE, 5'd0);
      5'd13:   w = uw(OP_MUL, SRC_K, SRC_ACC, DST_ACC, JMP_NONE, 5'd0);
      5'd14:   w = uw(OP_ADD, SRC_X0, SRC_ACC, DST_X, JMP_NONE, 5'd0);
      5'd15:   w = uw(OP_MUL, SRC_K, SRC_H, DST_ACC, JMP_NONE, 5'd0);
      5'd16:   w = uw(OP_SUB, SRC_ONE, SRC_ACC, DST_ACC, JMP_NONE, 5'd0);
      5'd17:   w = uw(OP_MUL, SRC_ACC, SRC_P0, DST_P, JMP_NONE, 5'd0);
      5'd18:   w = uw(OP_OUT, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_ALWAYS, 5'd0);
      default: w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_ALWAYS, 5'd0);
    endcase
    return w;
  endfunction

  function automatic logic [DW-1:0] mag_of(logic signed [DW-1:0] a);
    return a[DW-1] ? (~a) + DW'(1) : a;
  endfunction

  // sign and magnitude to a saturated signed word
  function automatic logic signed [DW-1:0] sat_mag(logic neg, logic [MAG_W-1:0] m);
    logic [DW-1:0] lo;
    lo = m[DW-1:0];
    if (neg) begin
      if (m > NEG_LIM) return MINV;
      return (~lo) + DW'(1);
    end
    if (m > POS_LIM) return MAXV;
    return lo;
  endfunction

  function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

endpackage

>>> rtl/skf_divider.sv
// Iterative restoring divider, two quotient bits per cycle, for the gain.
// Depends on skf_pkg.
module skf_divider import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,   // positive
  output logic                 busy,
  output logic                 fin,
  output logic signed [DW-1:0] quo
);

  localparam int ITER  = MAG_W / 2;
  localparam int CNT_W = $clog2(ITER);

  logic [CNT_W-1:0] cnt;
  logic [UW-1:0]    rem;
  logic [UW-1:0]    dv;
  logic [MAG_W-1:0] dvd;    // dividend bits shift out on top, quotient in below
  logic             neg;

  logic [DW-1:0] r1, r2, s1, s2;
  logic          q1, q2;

  always_comb begin
    r1 = {rem, dvd[MAG_W-1]};
    q1 = r1 >= {1'b0, dv};
    s1 = q1 ? r1 - {1'b0, dv} : r1;
    r2 = {s1[UW-1:0], dvd[MAG_W-2]};
    q2 = r2 >= {1'b0, dv};
    s2 = q2 ? r2 - {1'b0, dv} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= busy && !start && (cnt == CNT_W'(ITER - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ITER - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= den[UW-1:0];
      dvd <= {mag_of(num), {FB{1'b0}}};
      neg <= num[DW-1];
    end else if (busy) begin
      rem <= s2[UW-1:0];
      dvd <= {dvd[MAG_W-3:0], q1, q2};
    end
  end

  assign quo = sat_mag(neg, dvd);

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

>>> rtl/skf_datapath.sv
// Filter datapath: working registers, shared multiplier, saturating adder
// and the divider. Driven by one control word a step. Depends on skf_pkg.
module skf_datapath import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ucw_t                 ctrl,
  input  logic signed [DW-1:0] f,
  input  logic signed [DW-1:0] h,
  input  logic [UW-1:0]        q,
  input  logic [UW-1:0]        r,
  input  logic signed [DW-1:0] z,
  input  logic                 ld_x,
  input  logic                 ld_p,
  input  logic [DW-1:0]        ld_data,
  output logic signed [DW-1:0] x,
  output logic [UW-1:0]        p,
  output logic                 mul_done,
  output logic                 div_done,
  output logic                 den_le0
);

  logic signed [DW-1:0] x0, p0, t, den, k, acc;
  logic signed [DW-1:0] a_val, b_val, wb_val, div_quo;
  logic [2*DW-1:0]      prod;
  logic                 prod_neg, mul_ph, wb_en;
  logic                 div_start, div_busy;

  function automatic logic signed [DW-1:0] pick(src_t s, logic signed [DW-1:0] cx,
      logic [UW-1:0] cp, logic signed [DW-1:0] cx0, logic signed [DW-1:0] cp0,
      logic signed [DW-1:0] ct, logic signed [DW-1:0] cden,
      logic signed [DW-1:0] ck, logic signed [DW-1:0] cacc);
    case (s)
      SRC_ZERO: return '0;
      SRC_ONE:  return ONE;
      SRC_F:    return f;
      SRC_H:    return h;
      SRC_Q:    return {1'b0, q};
      SRC_R:    return {1'b0, r};
      SRC_Z:    return z;
      SRC_X:    return cx;
      SRC_P:    return {1'b0, cp};
      SRC_X0:   return cx0;
      SRC_P0:   return cp0;
      SRC_T:    return ct;
      SRC_DEN:  return cden;
      SRC_K:    return ck;
      SRC_ACC:  return cacc;
      default:  return '0;
    endcase
  endfunction

  assign a_val = pick(ctrl.a, x, p, x0, p0, t, den, k, acc);
  assign b_val = pick(ctrl.b, x, p, x0, p0, t, den, k, acc);

  assign mul_done  = (ctrl.op == OP_MUL) && mul_ph;
  assign div_start = (ctrl.op == OP_DIV) && !div_busy && !div_done;
  assign den_le0   = den[DW-1] || (den == '0);

  // multiply: the product of the magnitudes is registered, then shifted and saturated at write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_ph <= 1'b0;
    end else begin
      mul_ph <= (ctrl.op == OP_MUL) && !mul_ph;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= (2*DW)'(mag_of(a_val)) * (2*DW)'(mag_of(b_val));
    prod_neg <= a_val[DW-1] != b_val[DW-1];
  end

  skf_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (a_val),
    .den   (b_val),
    .busy  (div_busy),
    .fin   (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    wb_en  = 1'b0;
    wb_val = '0;
    case (ctrl.op)
      OP_MUL: begin
        wb_en  = mul_ph;
        wb_val = sat_mag(prod_neg, prod[FB +: MAG_W]);
      end
      OP_ADD: begin
        wb_en  = 1'b1;
        wb_val = sat_add(a_val, b_val);
      end
      OP_SUB: begin
        wb_en  = 1'b1;
        wb_val = sat_sub(a_val, b_val);
      end
      OP_DIV: begin
        wb_en  = div_done;
        wb_val = div_quo;
      end
      default: begin
        wb_en  = 1'b0;
        wb_val = '0;
      end
    endcase
  end

  // x and p are state and reset to the initial register values (zero)
  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      p <= '0;
    end else begin
      if (ld_x) begin
        x <= ld_data;
      end else if (wb_en && ctrl.dst == DST_X) begin
        x <= wb_val;
      end
      if (ld_p) begin
        p <= ld_data[UW-1:0];
      end else if (wb_en && ctrl.dst == DST_P) begin
        p <= wb_val[DW-1] ? '0 : wb_val[UW-1:0];   // clamp at zero
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      case (ctrl.dst)
        DST_X0:  x0  <= wb_val;
        DST_P0:  p0  <= wb_val;
        DST_T:   t   <= wb_val;
        DST_DEN: den <= wb_val;
        DST_K:   k   <= wb_val;
        DST_ACC: acc <= wb_val;
        default: ;
      endcase
    end
  end

  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ctrl.op == OP_DIV)
    else $error("divider result with no divide step in progress");

endmodule

>>> rtl/skf_sequencer.sv
// Microcode sequencer: step counter over the program in skf_pkg, with
// waits on multi-cycle steps and conditional jumps. Depends on skf_pkg.
module skf_sequencer import skf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ucw_t  ctrl
);

  logic [PC_W-1:0] pc, pc_next;
  logic            done, take;

  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.op)
      OP_IDLE: done = stat.in_fire;
      OP_MUL:  done = stat.mul_done;
      OP_DIV:  done = stat.div_done;
      OP_OUT:  done = stat.out_free;
      default: done = 1'b1;
    endcase
    case (ctrl.jmp)
      JMP_ALWAYS:  take = 1'b1;
      JMP_DEN_LE0: take = stat.den_le0;
      default:     take = 1'b0;
    endcase
    if (!done) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_IDLE && stat.in_fire) |=> pc == PC_W'(1))
    else $error("accepted sample did not start the program");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV && !stat.div_done) |=> pc == $past(pc))
    else $error("sequencer left the divide step early");

endmodule

>>> rtl/scalar_kalman_filter.sv
// Scalar Kalman filter in Q16.16: top level with the stream ports,
// configuration registers and output register. Depends on skf_pkg and
// skf_sequencer, skf_datapath (with skf_divider).
// The divide step is skipped when the gain denominator is zero or negative (zero gain).
// A new sample is accepted only once the previous result is in the output register;
// the multi-cycle steps are the 48-bit divide, at two quotient bits per cycle, and the
// nine multiplies.
// Reset (synchronous, rst high): F, Q, H, R = 1.0, estimate and covariance = 0.
module scalar_kalman_filter import skf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  // sample stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // [31:0] measurement
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // [31:0] estimate, [62:32] error_covariance, [63] 0
  // configuration writes
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [31:0]   wr_data
);

  // configuration registers
  logic signed [DW-1:0] tf, mf;
  logic [UW-1:0]        pn, mn;

  // sample latched at accept, result held until taken
  logic signed [DW-1:0] z;
  logic signed [DW-1:0] est_q;
  logic [UW-1:0]        cov_q;

  ucw_t                 ctrl;
  stat_t                stat;
  logic signed [DW-1:0] x;
  logic [UW-1:0]        p;
  logic                 in_fire, out_free, out_load;
  logic                 mul_done, div_done, den_le0;

  assign s_axis_tready = (ctrl.op == OP_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // output register frees up in the same cycle its beat is taken
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (ctrl.op == OP_OUT) && out_free;

  always_comb begin
    stat.in_fire  = in_fire;
    stat.out_free = out_free;
    stat.mul_done = mul_done;
    stat.div_done = div_done;
    stat.den_le0  = den_le0;
  end

  // writes to unknown indexes are dropped; initial estimate/covariance
  // writes go straight into the datapath state
  always_ff @(posedge clk) begin
    if (rst) begin
      tf <= ONE;
      pn <= ONE[UW-1:0];
      mf <= ONE;
      mn <= ONE[UW-1:0];
    end else if (wr_en) begin
      case (wr_index)
        REG_F:   tf <= wr_data;
        REG_Q:   pn <= wr_data[UW-1:0];
        REG_H:   mf <= wr_data;
        REG_R:   mn <= wr_data[UW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      z <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      est_q <= x;
      cov_q <= p;
    end
  end

  assign m_axis_tdata = {1'b0, cov_q, est_q};

  skf_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  skf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .f        (tf),
    .h        (mf),
    .q        (pn),
    .r        (mn),
    .z        (z),
    .ld_x     (wr_en && wr_index == REG_INIT_EST),
    .ld_p     (wr_en && wr_index == REG_INIT_COV),
    .ld_data  (wr_data),
    .x        (x),
    .p        (p),
    .mul_done (mul_done),
    .div_done (div_done),
    .den_le0  (den_le0)
  );

  a_out_from_step: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_axis_tvalid)) |-> $past(ctrl.op == OP_OUT))
    else $error("result beat raised outside the output step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("second sample accepted while one is in work");

endmodule

>>> test/scalar_kalman_filter_test.sv
// Self-checking bench for scalar_kalman_filter: a Q16.16 predictor inside a
// small scoreboard class checks every result beat against its own filter state.
// Depends on skf_pkg (register indexes) and the scalar_kalman_filter RTL.

localparam longint Q_MAX   = 64'sh0000_0000_7fff_ffff;
localparam longint Q_MIN   = -64'sh0000_0000_8000_0000;
localparam longint Q_ONE   = 64'sd65536;
localparam int     Q_FRAC  = 16;

// one result beat: estimate in the low word, covariance above it
typedef struct packed {
  logic [30:0]        cov;
  logic signed [31:0] est;
} kalman_fix_t;

class kalman_scoreboard;
  longint f, q, h, r;       // filter settings
  longint est, cov;         // filter state
  kalman_fix_t due_fixes[$];
  int mismatches;

  function new();
    f = Q_ONE;
    q = Q_ONE;
    h = Q_ONE;
    r = Q_ONE;
    est = 0;
    cov = 0;
    mismatches = 0;
  endfunction

  function longint saturate(bit neg, longint unsigned m);
    if (neg) return (m > 64'h8000_0000) ? Q_MIN : -longint'(m);
    return (m > 64'h7fff_ffff) ? Q_MAX : longint'(m);
  endfunction

  // magnitudes multiplied, fraction truncated, sign applied last
  function longint qmul(longint a, longint b);
    longint unsigned ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return saturate((a < 0) != (b < 0), (ma * mb) >> Q_FRAC);
  endfunction

  // divisor is always positive here
  function longint qdiv(longint num, longint den);
    longint unsigned n;
    n = (num < 0) ? -num : num;
    return saturate(num < 0, (n << Q_FRAC) / longint'(den));
  endfunction

  function longint qadd(longint a, longint b);
    longint s;
    s = a + b;
    if (s > Q_MAX) return Q_MAX;
    if (s < Q_MIN) return Q_MIN;
    return s;
  endfunction

  function longint qsub(longint a, longint b);
    return qadd(a, -b);
  endfunction

  function void write_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      skf_pkg::REG_F:        f = longint'(signed'(val));
      skf_pkg::REG_Q:        q = longint'(val[30:0]);
      skf_pkg::REG_H:        h = longint'(signed'(val));
      skf_pkg::REG_R:        r = longint'(val[30:0]);
      skf_pkg::REG_INIT_EST: est = longint'(signed'(val));
      skf_pkg::REG_INIT_COV: cov = longint'(val[30:0]);
      default: ;
    endcase
  endfunction

  // predict, gain, correct; queues the fix this sample must produce
  function void take_sample(logic [31:0] z_bits);
    longint z, x0, p0, t, den, k, innov;
    kalman_fix_t fix;
    z = longint'(signed'(z_bits));
    x0 = qmul(f, est);
    p0 = qadd(qmul(qmul(f, f), cov), q);
    t = qmul(h, p0);
    den = qadd(qmul(t, h), r);
    k = (den > 0) ? qdiv(t, den) : 0;
    innov = qsub(z, qmul(h, x0));
    est = qadd(x0, qmul(k, innov));
    cov = qmul(qsub(Q_ONE, qmul(k, h)), p0);
    if (cov < 0) cov = 0;
    if (cov > Q_MAX) cov = Q_MAX;
    fix.est = est[31:0];
    fix.cov = cov[30:0];
    due_fixes.push_back(fix);
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endfunction

  function void check_fix(logic [63:0] beat);
    kalman_fix_t got, want;
    got = beat[62:0];
    if (due_fixes.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result beat, expected none, actual %h", $time, beat);
      return;
    end
    want = due_fixes.pop_front();
    if (got.est !== want.est) report("estimate", want.est, got.est);
    if (got.cov !== want.cov) report("error_covariance", {1'b0, want.cov}, {1'b0, got.cov});
  endfunction

  function int outstanding();
    return due_fixes.size();
  endfunction
endclass

module scalar_kalman_filter_test;
  import skf_pkg::*;

  // indexes past the register file; writes there must change nothing
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] val;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // [31:0] measurement
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // [31:0] estimate, [62:32] error_covariance, [63] 0
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;

  kalman_scoreboard board;
  reg_write_t       reg_writes[$];
  int               send_wait_max = 12;   // 0 gives back-to-back stretches
  int               take_wait_max = 12;

  scalar_kalman_filter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always #4 clk = ~clk;

  // corner words: zero, +-1.0, both limits, +-1 lsb, alternating bits
  function automatic logic [31:0] corner_word(int sel);
    case (sel)
      0:       return 32'h0000_0000;
      1:       return 32'h0001_0000;
      2:       return 32'hffff_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      5:       return 32'h0000_0001;
      6:       return 32'hffff_ffff;
      7:       return 32'h5555_5555;
      default: return 32'haaaa_aaaa;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 6) == 0) return corner_word($urandom_range(0, 8));
    return $urandom;
  endfunction

  // F and H: near +-1.0 half the time so the filter tracks, otherwise wider or any value
  function automatic logic [31:0] rand_factor();
    logic [31:0] v;
    int sel;
    sel = $urandom_range(0, 7);
    v = 32'h0001_0000 + $urandom_range(0, 32'h8000) - 32'h4000;
    if (sel <= 2) return v;
    if (sel == 3) return -v;
    if (sel == 4) return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    if (sel == 5) return corner_word($urandom_range(0, 8));
    return $urandom;
  endfunction

  // Q, R, covariance: bit 31 is dropped by the block, so full words go in too
  function automatic logic [31:0] rand_noise();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h4_0000);
      4:          return 32'h0;
      5:          return 32'h7fff_ffff;
      6:          return 32'hffff_ffff;
      7:          return $urandom_range(0, 16);
      default:    return $urandom;
    endcase
  endfunction

  // a noisy signal around a level, with wild samples mixed in
  function automatic logic [31:0] next_sample(logic [31:0] level);
    if ($urandom_range(0, 9) < 7) return level + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    return rand_word();
  endfunction

  function automatic void queue_write(logic [2:0] idx, logic [31:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    reg_writes.push_back(w);
  endfunction

  // one write per clock; wr_en drops only after the last one
  task automatic load_regs();
    foreach (reg_writes[i]) begin
      wr_en <= 1'b1;
      wr_index <= reg_writes[i].idx;
      wr_data <= reg_writes[i].val;
      @(posedge clk);
      board.write_register(reg_writes[i].idx, reg_writes[i].val);
    end
    wr_en <= 1'b0;
    reg_writes.delete();
  endtask

  // tvalid stays up across back-to-back beats; it only drops ahead of a gap
  task automatic send_sample(logic [31:0] z);
    int gap;
    gap = $urandom_range(0, send_wait_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= z;
    do @(posedge clk); while (!s_axis_tready);
    board.take_sample(z);
  endtask

  // block idle again: every fix back, then a short settle for the sequencer
  task automatic drain(int extra);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic close_phase();
    s_axis_tvalid <= 1'b0;
    drain(4);
  endtask

  // result side: random stall before each beat, same rule for tready
  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, take_wait_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      board.check_fix(m_axis_tdata);
    end
  end

  initial begin : stimulus
    logic [31:0] level;
    int count, phase_len;
    board = new();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings (F = H = Q = R = 1.0, zero state): every corner word
    for (int i = 0; i <= 8; i++) send_sample(corner_word(i));
    close_phase();

    // zero gain: H = 0 and R = 0 leave the denominator at zero
    queue_write(REG_H, 32'h0);
    queue_write(REG_R, 32'h0);
    queue_write(REG_SPARE_A, 32'hffff_ffff);
    queue_write(REG_SPARE_B, 32'h1234_5678);
    load_regs();
    send_sample(corner_word(3));
    send_sample(corner_word(4));
    send_sample(corner_word(1));
    close_phase();

    // every register at an extreme; noise written with bit 31 set
    queue_write(REG_F, 32'h8000_0000);
    queue_write(REG_Q, 32'hffff_ffff);
    queue_write(REG_H, 32'h7fff_ffff);
    queue_write(REG_R, 32'hffff_ffff);
    queue_write(REG_INIT_EST, 32'h7fff_ffff);
    queue_write(REG_INIT_COV, 32'h7fff_ffff);
    load_regs();
    send_sample(corner_word(4));
    send_sample(corner_word(3));
    send_sample(corner_word(0));
    close_phase();

    // covariance clamp: tiny H with R = 0 rounds K*H above one, so
    // (1 - K*H) goes negative and the new covariance must clamp to zero
    queue_write(REG_F, 32'h0001_0000);
    queue_write(REG_Q, 32'h7fff_ffff);
    queue_write(REG_H, 32'h0000_0003);
    queue_write(REG_R, 32'h0);
    queue_write(REG_INIT_EST, 32'h0);
    queue_write(REG_INIT_COV, 32'h0);
    load_regs();
    send_sample(corner_word(1));
    send_sample(corner_word(2));
    send_sample(corner_word(0));
    close_phase();
    queue_write(REG_H, 32'hffff_fffd);
    load_regs();
    send_sample(corner_word(1));
    send_sample(corner_word(6));
    close_phase();

    // random phases: new settings (each register with even odds), then a
    // run of samples around a random level; some phases run without gaps
    count = 0;
    while (count < 1030) begin
      if ($urandom_range(0, 1)) queue_write(REG_F, rand_factor());
      if ($urandom_range(0, 1)) queue_write(REG_Q, rand_noise());
      if ($urandom_range(0, 1)) queue_write(REG_H, rand_factor());
      if ($urandom_range(0, 1)) queue_write(REG_R, rand_noise());
      if ($urandom_range(0, 1)) queue_write(REG_INIT_EST, rand_word());
      if ($urandom_range(0, 1)) queue_write(REG_INIT_COV, rand_noise());
      if ($urandom_range(0, 9) == 0)
        queue_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      load_regs();
      send_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      take_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      level = $signed($urandom) >>> $urandom_range(3, 15);
      phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : $urandom_range(20, 80);
      repeat (phase_len) send_sample(next_sample(level));
      count += phase_len;
      close_phase();
    end

    // any result beat beyond the expected ones shows up in this window
    drain(60);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // slowest run ends well inside this timeout
  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/skf_pkg.sv
rtl/skf_divider.sv
rtl/skf_datapath.sv
rtl/skf_sequencer.sv
rtl/scalar_kalman_filter.sv
test/scalar_kalman_filter_test.sv
